// ===== rtl/core/u64_radix_digit_emitter_core_defines.svh =====
// Assertion macros shared by the radix digit emitter RTL
`ifndef U64_RADIX_DIGIT_EMITTER_CORE_DEFINES_SVH
`define U64_RADIX_DIGIT_EMITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rde assertion failed");

// Next-cycle implication, checked out of reset
`define RDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rde assertion failed");

`endif

// ===== rtl/core/rde_pkg.sv =====
// Shared types, constants and functions of the radix digit emitter
`default_nettype none
package rde_pkg;

    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int NUM_BYTES = VALUE_W / BYTE_W;
    localparam int BIDX_W    = $clog2(NUM_BYTES);
    localparam int CHAR_W    = 8;
    localparam int RDX_W     = 9;
    localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd32;
    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 224;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_rde_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_rde_cmd;

    // Datapath to controller
    typedef struct packed {
        logic digit_done;
        logic quot_zero;
        logic rd_last;
    } t_rde_sts;

    // Clamp the build-time radix into the supported range
    function automatic int eff_radix(input int radix);
        int r;
        r = radix;
        if (r < RADIX_MIN) r = RADIX_MIN;
        if (r > RADIX_MAX) r = RADIX_MAX;
        return r;
    endfunction

    // Number of digits a full-scale 64-bit value needs in this radix
    function automatic int max_digits(input int radix);
        logic [VALUE_W+8:0] p;
        int n;
        p = (VALUE_W+9)'(1);
        n = 0;
        for (int i = 0; i <= VALUE_W; i++) begin
            if (p < ((VALUE_W+9)'(1) << VALUE_W)) begin
                p = p * (VALUE_W+9)'(radix);
                n = n + 1;
            end
        end
        return n;
    endfunction

    // Index of the highest nonzero byte, zero for a zero value
    function automatic logic [BIDX_W-1:0] top_byte(input logic [VALUE_W-1:0] v);
        logic [BIDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (v[i*BYTE_W +: BYTE_W] != '0) idx = BIDX_W'(i);
        end
        return idx;
    endfunction

    // Restoring divide of {rem, b} by radix, one bit per step: {quotient byte, remainder}
    function automatic logic [2*BYTE_W-1:0] div_byte(input logic [BYTE_W-1:0] rem,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [RDX_W-1:0] radix);
        logic [RDX_W-1:0]  acc;
        logic [BYTE_W-1:0] q;
        acc = {1'b0, rem};
        q   = '0;
        for (int i = BYTE_W-1; i >= 0; i--) begin
            acc = {acc[BYTE_W-1:0], b[i]};
            if (acc >= radix) begin
                acc  = acc - radix;
                q[i] = 1'b1;
            end
        end
        return {q, acc[BYTE_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rde_ctrl.sv =====
// Sequencer of the radix digit emitter: load, divide, emit
`default_nettype none
module rde_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire rde_pkg::t_rde_sts i_sts,
    output rde_pkg::t_rde_cmd      o_cmd,
    output logic                   o_busy
);

    rde_pkg::t_rde_state r_state;
    rde_pkg::t_rde_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rde_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance on start, on the final digit and on the last read
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rde_pkg::S_IDLE: begin
                if (i_start) n_state = rde_pkg::S_DIV;
            end
            rde_pkg::S_DIV: begin
                if (i_sts.digit_done && i_sts.quot_zero) n_state = rde_pkg::S_EMIT;
            end
            rde_pkg::S_EMIT: begin
                if (i_sts.rd_last) n_state = rde_pkg::S_IDLE;
            end
            default: n_state = rde_pkg::S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            rde_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            rde_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
            end
            rde_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/rde_dp.sv =====
// Datapath: byte-wide divide by the radix, digit store and output register
`default_nettype none
module rde_dp #(
    parameter int EFF_RADIX = 95,
    parameter int DEPTH     = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [rde_pkg::VALUE_W-1:0]  i_value,
    input  wire rde_pkg::t_rde_cmd            i_cmd,
    output rde_pkg::t_rde_sts                 o_sts,
    output logic                              o_valid,
    output logic [rde_pkg::CHAR_W-1:0]        o_digit_char,
    output logic                              o_last_digit
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [rde_pkg::RDX_W-1:0] RDX = rde_pkg::RDX_W'(EFF_RADIX);

    logic [rde_pkg::VALUE_W-1:0] r_quot;
    logic [rde_pkg::VALUE_W-1:0] n_quot;
    logic [rde_pkg::BYTE_W-1:0]  r_rem;
    logic [rde_pkg::BIDX_W-1:0]  r_bidx;
    logic [IW-1:0]               r_count;
    logic [IW-1:0]               r_rd_idx;
    logic [rde_pkg::CHAR_W-1:0]  r_store [DEPTH];
    logic [rde_pkg::CHAR_W-1:0]  r_rd_data;
    logic                        r_out_vld;
    logic                        r_out_last;
    logic [rde_pkg::BYTE_W-1:0]  step_q;
    logic [rde_pkg::BYTE_W-1:0]  step_rem;

    // Divide the current byte and fold the quotient byte back in place
    always_comb begin
        {step_q, step_rem} = rde_pkg::div_byte(r_rem, r_quot[r_bidx*rde_pkg::BYTE_W +:
                                                rde_pkg::BYTE_W], RDX);
        n_quot = r_quot;
        n_quot[r_bidx*rde_pkg::BYTE_W +: rde_pkg::BYTE_W] = step_q;
    end

    // Report digit completion and end of conversion
    always_comb begin
        o_sts.digit_done = (r_bidx == '0);
        o_sts.quot_zero  = (n_quot == '0);
        o_sts.rd_last    = (r_rd_idx == '0);
    end

    // Step through the quotient, one byte a cycle, most significant byte first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx  <= '0;
            r_count <= '0;
            r_rem   <= '0;
        end else if (i_cmd.load) begin
            r_quot  <= i_value;
            r_rem   <= '0;
            r_bidx  <= rde_pkg::top_byte(i_value);
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_quot <= n_quot;
            if (r_bidx == '0) begin
                r_rem   <= '0;
                r_bidx  <= rde_pkg::top_byte(n_quot);
                r_count <= r_count + IW'(1);
            end else begin
                r_rem  <= step_rem;
                r_bidx <= r_bidx - rde_pkg::BIDX_W'(1);
            end
        end
    end

    // Point the read side at the most significant digit once the quotient runs out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.step && (r_bidx == '0) && (n_quot == '0)) begin
            r_rd_idx <= r_count;
        end else if (i_cmd.emit) begin
            r_rd_idx <= r_rd_idx - IW'(1);
        end
    end

    // Write each finished digit character
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && (r_bidx == '0)) begin
            r_store[r_count] <= step_rem + rde_pkg::DIGIT_OFFSET;
        end
    end

    // Read digits back, most significant first
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    // Mark each transaction for one cycle, flag the final digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_out_vld  <= i_cmd.emit;
            r_out_last <= i_cmd.emit && (r_rd_idx == '0);
        end
    end

    assign o_valid      = r_out_vld;
    assign o_digit_char = r_rd_data;
    assign o_last_digit = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/core/u64_radix_digit_emitter_core.sv =====
// Top level: unsigned 64-bit value to radix digit characters, most significant first
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   input   | in        | start, busy         | i_value[63:0]
//   result  | out       | o_valid (strobe)    | o_digit_char[7:0], o_last_digit
//
// A value is taken when start is high and busy is low. Each digit is found by the
// byte-wide divide over each significant byte of the current quotient (at least one);
// all digits are then read back from the digit store. Results are registered and
// follow their reads in the next cycle, the last in the cycle busy drops; the receiver
// cannot stall. Reset is synchronous and clears control state and the running
// remainder only.
`default_nettype none
`include "u64_radix_digit_emitter_core_defines.svh"
module u64_radix_digit_emitter_core #(
    parameter int RADIX = 95
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [rde_pkg::VALUE_W-1:0]  i_value,
    output logic                              o_valid,
    output logic [rde_pkg::CHAR_W-1:0]        o_digit_char,
    output logic                              o_last_digit
);

    localparam int EFF_RADIX = rde_pkg::eff_radix(RADIX);
    localparam int DEPTH     = rde_pkg::max_digits(EFF_RADIX);

    rde_pkg::t_rde_cmd cmd;
    rde_pkg::t_rde_sts sts;
    logic              char_ok;

    rde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rde_dp #(
        .EFF_RADIX (EFF_RADIX),
        .DEPTH     (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // Keep digit characters inside the radix alphabet
    assign char_ok = (o_digit_char >= rde_pkg::DIGIT_OFFSET) &&
                     (int'(o_digit_char) < int'(rde_pkg::DIGIT_OFFSET) + EFF_RADIX);

    // Check sequencing of the emitted digit stream
    `RDE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `RDE_ASSERT_NXT(a_digits_contig, i_clk, i_rst_n, o_valid && !o_last_digit, o_valid)
    `RDE_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last_digit, !o_valid)
    `RDE_ASSERT_IMP(a_char_range, i_clk, i_rst_n, o_valid, char_ok)

endmodule
`default_nettype wire

// ===== tb/u64_radix_digit_emitter_core_tb.sv =====
// Self-checking testbench for the 64-bit radix digit emitter core
`default_nettype none
module u64_radix_digit_emitter_core_tb;

    localparam int RADIX        = 95;
    localparam int DIR_ROWS     = 18;
    localparam int RANDOM_ITEMS = 452;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 250000;

    // Clamp the radix the same way the core does at build time
    localparam logic [63:0] BASE = 64'((RADIX < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN :
                                       (RADIX > rde_pkg::RADIX_MAX) ? rde_pkg::RADIX_MAX :
                                       RADIX);

    // One emitted digit character and its end-of-string flag
    typedef struct packed {
        logic [rde_pkg::CHAR_W-1:0] chr;
        logic                       last;
    } t_digit;

    // Directed row: n_typed of 0 means the predictor supplies the digits,
    // 1 means char_lo alone, 2 means char_hi then char_lo
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  n_typed;
        logic [7:0]  char_hi;
        logic [7:0]  char_lo;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_value;
    logic        o_valid;
    logic [7:0]  o_digit_char;
    logic        o_last_digit;

    t_digit digits_pending[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     no_gap_stretch = 1'b0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{64'd0,                     2'd1, 8'd0,   8'd32},
        '{64'd1,                     2'd1, 8'd0,   8'd33},
        '{64'd94,                    2'd1, 8'd0,   8'd126},
        '{64'd95,                    2'd2, 8'd33,  8'd32},
        '{64'd96,                    2'd2, 8'd33,  8'd33},
        '{64'd9024,                  2'd2, 8'd126, 8'd126},
        '{64'd9025,                  2'd0, 8'd0,   8'd0},
        '{64'd630249409724609374,    2'd0, 8'd0,   8'd0},
        '{64'd630249409724609375,    2'd0, 8'd0,   8'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF,   2'd0, 8'd0,   8'd0},
        '{64'hFFFF_FFFF_FFFF_FFFE,   2'd0, 8'd0,   8'd0},
        '{64'h8000_0000_0000_0000,   2'd0, 8'd0,   8'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA,   2'd0, 8'd0,   8'd0},
        '{64'h5555_5555_5555_5555,   2'd0, 8'd0,   8'd0},
        '{64'h0000_0000_0000_00FF,   2'd0, 8'd0,   8'd0},
        '{64'h0000_0000_0000_0100,   2'd0, 8'd0,   8'd0},
        '{64'h0000_0001_0000_0000,   2'd0, 8'd0,   8'd0},
        '{64'h00FF_FFFF_FFFF_FFFF,   2'd0, 8'd0,   8'd0}
    };

    u64_radix_digit_emitter_core #(
        .RADIX(RADIX)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Divide down by the base and queue the digit characters, most significant first
    function automatic void predict_digits(input logic [63:0] value);
        logic [63:0] quot;
        logic [7:0]  rev[$];
        quot = value;
        do begin
            rev.push_back(8'(quot % BASE) + rde_pkg::DIGIT_OFFSET);
            quot = quot / BASE;
        end while (quot != 64'd0);
        for (int k = rev.size() - 1; k >= 0; k--) begin
            digits_pending.push_back('{chr: rev[k], last: (k == 0)});
        end
    endfunction

    // Idle for a random gap, offer one value, and hold it until the core takes it
    task automatic send_value(input logic [63:0] value, input logic [1:0] n_typed,
                              input logic [7:0] char_hi, input logic [7:0] char_lo);
        int gap;
        if ($urandom_range(0, 15) == 0) no_gap_stretch = !no_gap_stretch;
        gap = no_gap_stretch ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Transaction accepted at this edge: queue what it must produce
        if (n_typed == 2'd0) begin
            predict_digits(value);
        end else begin
            if (n_typed == 2'd2) digits_pending.push_back('{chr: char_hi, last: 1'b0});
            digits_pending.push_back('{chr: char_lo, last: 1'b1});
        end
    endtask

    // Check each strobed digit against the oldest expectation
    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_valid) begin
            if (digits_pending.size() == 0) begin
                $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                         $time, o_digit_char, o_last_digit);
                mismatch_count++;
            end else begin
                want = digits_pending.pop_front();
                if (o_digit_char !== want.chr) begin
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, want.chr, o_digit_char);
                    mismatch_count++;
                end
                if (o_last_digit !== want.last) begin
                    $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last_digit);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int          kind;
        int          nbytes;
        logic [63:0] value;
        logic [63:0] power;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = 64'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table: extremes, digit-count boundaries, byte boundaries
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_value(dir_rows[r].value, dir_rows[r].n_typed,
                       dir_rows[r].char_hi, dir_rows[r].char_lo);
        end

        // Random values, mixed across magnitudes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind  = $urandom_range(0, 9);
            value = {$urandom, $urandom};
            case (kind)
                4, 5: begin
                    // limit to a random number of significant bytes
                    nbytes = $urandom_range(1, 8);
                    if (nbytes < 8) value = value & ((64'd1 << (8 * nbytes)) - 64'd1);
                end
                6: begin
                    value = 64'($urandom_range(0, 200));
                end
                7: begin
                    // land on or next to a power of the base
                    power = 64'd1;
                    repeat ($urandom_range(0, 9)) power = power * BASE;
                    value = power + 64'($urandom_range(0, 2)) - 64'd1;
                end
                8: begin
                    value = 64'd1 << $urandom_range(0, 63);
                    if ($urandom_range(0, 1) == 1) value = value - 64'd1;
                end
                default: begin
                end
            endcase
            send_value(value, 2'd0, 8'd0, 8'd0);
        end

        @(negedge i_clk);
        start <= 1'b0;

        // Drain outstanding digits, then watch for strays
        while (digits_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
